// ===== rtl/tlre_pkg.sv =====
// ---------------------------------------------------------------------------
// Token line run expander package
// Shared payload types, command codes and token field positions.
// ---------------------------------------------------------------------------
`default_nettype none

package tlre_pkg;

   localparam int WORD_W     = 32;
   localparam int COUNT_W    = 12;
   localparam int TOKEN_W    = 16;
   localparam int ENTRY_ID_W = 9;
   localparam int LANE_W     = 2;
   localparam int CMD_W      = 2;
   localparam int LIT_LEFT_W = 15;
   localparam int RUN_LEN_W  = 6;

   // Item commands
   localparam logic [CMD_W-1:0] CMD_TOKEN = 2'd0;
   localparam logic [CMD_W-1:0] CMD_EOL   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

   // Table lanes
   localparam logic [LANE_W-1:0] LANE_A = 2'd0;
   localparam logic [LANE_W-1:0] LANE_B = 2'd1;
   localparam logic [LANE_W-1:0] LANE_C = 2'd2;

   // Token layout
   localparam int LIT_FLAG_BIT = 15;
   localparam int RUN_LEN_LSB  = 9;
   localparam int LIT_ID_LSB   = 4;

   localparam logic [COUNT_W-1:0] LINE_WORDS_RESET = 12'd320;

   typedef struct packed {
      logic [CMD_W-1:0]      cmd;
      logic [TOKEN_W-1:0]    token;
      logic [ENTRY_ID_W-1:0] entry_id;
      logic [LANE_W-1:0]     entry_lane;
      logic [WORD_W-1:0]     entry_word;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0]  lane_a_word;
      logic [WORD_W-1:0]  lane_b_word;
      logic [WORD_W-1:0]  lane_c_word;
      logic [COUNT_W-1:0] repeat_count;
      logic               is_padding;
      logic               line_done;
   } rsp_type;

   typedef struct packed {
      logic                  en;
      logic [ENTRY_ID_W-1:0] id;
      logic [LANE_W-1:0]     lane;
      logic [WORD_W-1:0]     word;
   } tbl_wr_type;

   typedef struct packed {
      logic                  en;
      logic [ENTRY_ID_W-1:0] id;
   } tbl_rd_type;

   typedef struct packed {
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic [WORD_W-1:0] c;
   } tbl_data_type;

endpackage

`default_nettype wire

// ===== rtl/tlre_table.sv =====
// ---------------------------------------------------------------------------
// Token line run expander word table
// Three lane memories with one write port and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module tlre_table #(
   parameter int TABLE_ENTRIES = 512
) (
   input  wire                    clock,
   input  tlre_pkg::tbl_wr_type   wr,
   input  tlre_pkg::tbl_rd_type   rd,
   output tlre_pkg::tbl_data_type rd_data
);

   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int CW = tlre_pkg::ENTRY_ID_W + 1;

   logic [tlre_pkg::WORD_W-1:0] mem_a [TABLE_ENTRIES];
   logic [tlre_pkg::WORD_W-1:0] mem_b [TABLE_ENTRIES];
   logic [tlre_pkg::WORD_W-1:0] mem_c [TABLE_ENTRIES];

   logic [tlre_pkg::WORD_W-1:0] rd_a_ff;
   logic [tlre_pkg::WORD_W-1:0] rd_b_ff;
   logic [tlre_pkg::WORD_W-1:0] rd_c_ff;

   logic          wr_in_range;
   logic [AW-1:0] wr_idx;
   logic [AW-1:0] rd_idx;

   assign wr_in_range = {1'b0, wr.id} < CW'(TABLE_ENTRIES);
   assign wr_idx      = wr.id[AW-1:0];
   assign rd_idx      = rd.id[AW-1:0];

   always_ff @(posedge clock) begin
      if (wr.en && wr_in_range) begin
         case (wr.lane)
            tlre_pkg::LANE_A: mem_a[wr_idx] <= wr.word;
            tlre_pkg::LANE_B: mem_b[wr_idx] <= wr.word;
            tlre_pkg::LANE_C: mem_c[wr_idx] <= wr.word;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_a_ff <= mem_a[rd_idx];
         rd_b_ff <= mem_b[rd_idx];
         rd_c_ff <= mem_c[rd_idx];
      end
   end

   assign rd_data.a = rd_a_ff;
   assign rd_data.b = rd_b_ff;
   assign rd_data.c = rd_c_ff;

endmodule

`default_nettype wire

// ===== rtl/token_line_run_expander_top.sv =====
// ---------------------------------------------------------------------------
// Token line run expander
// Expands run and literal tokens of one display line into three-lane table
// words, each result carrying a repeat count.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  req_     | in        | req_valid/req_stall  | cmd, token, entry_id/lane/word
//  rsp_     | out       | rsp_valid/rsp_stall  | three lane words, count, flags
//  csr_     | in        | csr_wr_en            | line_words (12 bits)
//
// One item is taken every cycle while req_stall is low; a result appears in the
// cycle after its item, from the registered read of the lane memories.
// While a result is held by rsp_stall, req_stall is raised in the same cycle.
// Reset is synchronous and clears the line position, the literal count and
// the output valid; line_words returns to 320. Table contents are not reset.
// ---------------------------------------------------------------------------
`default_nettype none

module token_line_run_expander_top #(
   parameter int TABLE_ENTRIES  = 512,
   parameter int MAX_LINE_WORDS = 2048
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_stall,
   input  tlre_pkg::req_type                 req,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output tlre_pkg::rsp_type                 rsp,
   input  wire                               csr_wr_en,
   input  wire  [tlre_pkg::COUNT_W-1:0]      csr_wr_data
);

   localparam int LW = tlre_pkg::COUNT_W + 1;
   localparam int CW = tlre_pkg::ENTRY_ID_W + 1;

   logic [tlre_pkg::COUNT_W-1:0]    line_words_ff;
   logic [tlre_pkg::COUNT_W-1:0]    slots_filled_ff, slots_filled_in;
   logic [tlre_pkg::LIT_LEFT_W-1:0] literal_left_ff, literal_left_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [tlre_pkg::COUNT_W-1:0]    count_ff;
   logic                            pad_ff;
   logic                            zero_ff;

   logic                            accept;
   logic [LW-1:0]                   line_len;
   logic [LW-1:0]                   room;
   logic                            room_nz;
   logic                            is_tok, is_eol;
   logic                            lit_act, hdr, run;
   logic                            has_result;
   logic [tlre_pkg::RUN_LEN_W:0]    run_len;
   logic [LW-1:0]                   run_cnt;
   logic [tlre_pkg::COUNT_W-1:0]    res_count;
   logic [tlre_pkg::ENTRY_ID_W-1:0] res_id;

   tlre_pkg::tbl_wr_type            tbl_wr;
   tlre_pkg::tbl_rd_type            tbl_rd;
   tlre_pkg::tbl_data_type          tbl_data;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // Room left in the line; a line length lowered below the position counts as full.
   always_comb begin
      if ({1'b0, line_words_ff} > LW'(MAX_LINE_WORDS)) begin
         line_len = LW'(MAX_LINE_WORDS);
      end else begin
         line_len = {1'b0, line_words_ff};
      end
      if ({1'b0, slots_filled_ff} >= line_len) begin
         room = '0;
      end else begin
         room = line_len - {1'b0, slots_filled_ff};
      end
      room_nz = room != '0;
   end

   always_comb begin
      is_tok  = req.cmd == tlre_pkg::CMD_TOKEN;
      is_eol  = req.cmd == tlre_pkg::CMD_EOL;
      lit_act = is_tok && room_nz && (literal_left_ff != '0);
      hdr     = is_tok && room_nz && (literal_left_ff == '0)
                && req.token[tlre_pkg::LIT_FLAG_BIT];
      run     = is_tok && room_nz && (literal_left_ff == '0)
                && !req.token[tlre_pkg::LIT_FLAG_BIT];
      has_result = is_eol || lit_act || run;

      run_len = {1'b0, req.token[tlre_pkg::RUN_LEN_LSB +: tlre_pkg::RUN_LEN_W]}
                + (tlre_pkg::RUN_LEN_W + 1)'(1);
      if (LW'(run_len) > room) begin
         run_cnt = room;
      end else begin
         run_cnt = LW'(run_len);
      end

      if (is_eol) begin
         res_count = room[tlre_pkg::COUNT_W-1:0];
         res_id    = '0;
      end else if (lit_act) begin
         res_count = tlre_pkg::COUNT_W'(1);
         res_id    = req.token[tlre_pkg::LIT_ID_LSB +: tlre_pkg::ENTRY_ID_W];
      end else begin
         res_count = run_cnt[tlre_pkg::COUNT_W-1:0];
         res_id    = req.token[tlre_pkg::ENTRY_ID_W-1:0];
      end
   end

   always_comb begin
      slots_filled_in = slots_filled_ff;
      literal_left_in = literal_left_ff;
      if (accept) begin
         if (is_eol) begin
            slots_filled_in = '0;
            literal_left_in = '0;
         end else if (lit_act) begin
            slots_filled_in = slots_filled_ff + tlre_pkg::COUNT_W'(1);
            literal_left_in = literal_left_ff - tlre_pkg::LIT_LEFT_W'(1);
         end else if (hdr) begin
            literal_left_in = req.token[tlre_pkg::LIT_LEFT_W-1:0];
         end else if (run) begin
            slots_filled_in = slots_filled_ff + run_cnt[tlre_pkg::COUNT_W-1:0];
         end
      end
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = has_result;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_words_ff   <= tlre_pkg::LINE_WORDS_RESET;
         slots_filled_ff <= '0;
         literal_left_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            line_words_ff <= csr_wr_data;
         end
         slots_filled_ff <= slots_filled_in;
         literal_left_ff <= literal_left_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && has_result) begin
         count_ff <= res_count;
         pad_ff   <= is_eol;
         zero_ff  <= {1'b0, res_id} >= CW'(TABLE_ENTRIES);
      end
   end

   always_comb begin
      tbl_wr.en   = accept && (req.cmd == tlre_pkg::CMD_WRITE);
      tbl_wr.id   = req.entry_id;
      tbl_wr.lane = req.entry_lane;
      tbl_wr.word = req.entry_word;
      tbl_rd.en   = accept && has_result;
      tbl_rd.id   = res_id;
   end

   tlre_table #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr      (tbl_wr),
      .rd      (tbl_rd),
      .rd_data (tbl_data)
   );

   // Entries beyond the table read as zero words.
   always_comb begin
      rsp_valid        = rsp_valid_ff;
      rsp.lane_a_word  = zero_ff ? '0 : tbl_data.a;
      rsp.lane_b_word  = zero_ff ? '0 : tbl_data.b;
      rsp.lane_c_word  = zero_ff ? '0 : tbl_data.c;
      rsp.repeat_count = count_ff;
      rsp.is_padding   = pad_ff;
      rsp.line_done    = pad_ff;
   end

endmodule

`default_nettype wire

// ===== rtl/tlre_checker.sv =====
// ---------------------------------------------------------------------------
// Token line run expander port checker
// Watches the top level's ports and flags behaviour the block never shows.
// ---------------------------------------------------------------------------
`default_nettype none

module tlre_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_valid,
   input wire                          req_stall,
   input tlre_pkg::req_type            req,
   input wire                          rsp_valid,
   input wire                          rsp_stall,
   input tlre_pkg::rsp_type            rsp
);

   // A held result must not change under the stall.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
      else $error("result changed while stalled");

   // Only the end-of-line result pads, and it always closes the line.
   a_done_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp.line_done == rsp.is_padding)
      else $error("line_done and is_padding disagree");

   // An end-of-line transfer always gives a closing result in the next cycle.
   a_eol_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req.cmd == tlre_pkg::CMD_EOL
      |=> rsp_valid && rsp.line_done)
      else $error("end of line gave no closing result");

   // A table write transfer never produces a result.
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req.cmd == tlre_pkg::CMD_WRITE |=> !rsp_valid)
      else $error("table write produced a result");

   // A token result always covers at least one slot.
   a_token_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp.line_done |-> rsp.repeat_count != '0)
      else $error("token result with zero repeat count");

endmodule

bind token_line_run_expander_top tlre_checker u_tlre_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req       (req),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp       (rsp)
);

`default_nettype wire
